>>> hdl/slr_pkg.sv
// Shared types and constants for the stereo linear resampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package slr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = 20;
	localparam int MAX_OUT   = 4;
	localparam int CNT_W     = $clog2(MAX_OUT);

	// phase accumulator: holds a stored phase plus one step during a run
	localparam int ACC_W = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 2;
	localparam logic [ACC_W-1:0] PHASE_ONE = ACC_W'(1) << FRAC_BITS;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(60211);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       track_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       run_last;
	} out_item_t;

	// one interpolation job, front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] prev_l;
		logic signed [SAMPLE_W-1:0] prev_r;
		logic signed [SAMPLE_W-1:0] new_l;
		logic signed [SAMPLE_W-1:0] new_r;
		logic [FRAC_BITS-1:0]       frac;
		logic                       run_last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

>>> hdl/slr_queue.sv
// Small job queue between the front sequencer and the interpolation back end.
// Depends on slr_pkg.
`default_nettype none

module slr_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  slr_pkg::job_t    push_data,
	input  wire              pop,
	output slr_pkg::job_t    pop_data,
	output slr_pkg::q_status_t status
);
	import slr_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

>>> hdl/slr_front.sv
// Front sequencer: accepts frames, keeps previous frame, phase and primed flag,
// and issues one interpolation job per cycle unless the queue is full. Depends on slr_pkg.
`default_nettype none

module slr_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  slr_pkg::in_item_t           in_data,
	input  wire                         cfg_we,
	input  wire [slr_pkg::STEP_W-1:0]   cfg_data,
	input  slr_pkg::q_status_t          q_status,
	output logic                        push,
	output slr_pkg::job_t               job
);
	import slr_pkg::*;

	logic [STEP_W-1:0]         step_q;
	in_item_t                  item_q;
	logic                      item_v_q;
	logic                      primed_q;
	logic [ACC_W-1:0]          phase_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SAMPLE_W-1:0] prev_l_q;
	logic signed [SAMPLE_W-1:0] prev_r_q;

	logic [ACC_W-1:0] sum;
	logic [ACC_W-1:0] base;
	logic [ACC_W-1:0] phase_end;
	logic             below_one;
	logic             last_job;
	logic             done;
	logic             accept;

	always_comb begin
		sum       = phase_q + ACC_W'(step_q);
		below_one = (phase_q < PHASE_ONE);
		last_job  = (sum >= PHASE_ONE) || (cnt_q == CNT_W'(MAX_OUT - 1));
		push      = item_v_q && primed_q && below_one && !q_status.full;
		// finish on an unprimed frame, on a frame with no output, or with the final job
		done      = item_v_q && (!primed_q || !below_one || (push && last_job));
		base      = below_one ? sum : phase_q;
		// cap reached with phase still under one: phase restarts at zero
		phase_end = (base >= PHASE_ONE) ? (base - PHASE_ONE) : '0;
		in_stall  = item_v_q && !done;
		accept    = in_valid && !in_stall;
	end

	always_comb begin
		job.prev_l   = prev_l_q;
		job.prev_r   = prev_r_q;
		job.new_l    = item_q.left_in;
		job.new_r    = item_q.right_in;
		job.frac     = phase_q[FRAC_BITS-1:0];
		job.run_last = last_job;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RESET;
			item_v_q <= 1'b0;
			primed_q <= 1'b0;
			phase_q  <= '0;
			cnt_q    <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else begin
			if (cfg_we) step_q <= cfg_data;

			if (accept)    item_v_q <= 1'b1;
			else if (done) item_v_q <= 1'b0;

			if (done) begin
				cnt_q <= '0;
				if (item_q.track_last) begin
					primed_q <= 1'b0;
					phase_q  <= '0;
					prev_l_q <= '0;
					prev_r_q <= '0;
				end else begin
					primed_q <= 1'b1;
					if (primed_q) phase_q <= phase_end;
					prev_l_q <= item_q.left_in;
					prev_r_q <= item_q.right_in;
				end
			end else if (push) begin
				phase_q <= sum;
				cnt_q   <= cnt_q + CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_push_needs_prime: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (item_v_q && primed_q))
		else $error("job issued without a primed frame");

	a_track_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && item_q.track_last) |=> (!primed_q && phase_q == '0))
		else $error("state not cleared after track end");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !last_job) |=> (item_v_q && cnt_q != '0))
		else $error("run ended before its last job");
`endif

endmodule

`default_nettype wire

>>> hdl/slr_back.sv
// Back end: three-stage interpolation pipeline, prev + trunc((new - prev) * frac),
// with the output register as last stage. Depends on slr_pkg.
`default_nettype none

module slr_back (
	input  wire                clk,
	input  wire                arst_n,
	input  slr_pkg::job_t      job,
	input  slr_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  wire                out_stall,
	output slr_pkg::out_item_t out_data
);
	import slr_pkg::*;

	localparam int PROD_W = SAMPLE_W + FRAC_BITS;

	logic adv;
	logic v_s1, v_s2, v_s3;

	logic signed [SAMPLE_W:0]   diff [2];
	logic [SAMPLE_W:0]          ndiff [2];
	logic signed [SAMPLE_W-1:0] prev_in [2];
	logic signed [SAMPLE_W-1:0] new_in [2];

	logic signed [SAMPLE_W-1:0] a_s1 [2];
	logic [SAMPLE_W-1:0]        mag_s1 [2];
	logic                       neg_s1 [2];
	logic [FRAC_BITS-1:0]       frac_s1;
	logic                       last_s1;

	logic signed [SAMPLE_W-1:0] a_s2 [2];
	logic [PROD_W-1:0]          prod_s2 [2];
	logic                       neg_s2 [2];
	logic                       last_s2;

	logic [SAMPLE_W-1:0]        t_s2 [2];
	logic signed [SAMPLE_W-1:0] res [2];
	logic signed [SAMPLE_W-1:0] res_s3 [2];
	logic                       last_s3;

	assign adv = !(v_s3 && out_stall);
	assign pop = adv && !q_status.empty;

	always_comb begin
		prev_in[0] = job.prev_l;
		prev_in[1] = job.prev_r;
		new_in[0]  = job.new_l;
		new_in[1]  = job.new_r;
		for (int i = 0; i < 2; i++) begin
			diff[i]  = {new_in[i][SAMPLE_W-1], new_in[i]} - {prev_in[i][SAMPLE_W-1], prev_in[i]};
			ndiff[i] = -diff[i];
			t_s2[i]  = prod_s2[i][FRAC_BITS +: SAMPLE_W];
			// truncation toward zero: scale the magnitude, then apply the sign
			res[i]   = neg_s2[i] ? (a_s2[i] - t_s2[i]) : (a_s2[i] + t_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 2; i++) begin
				a_s1[i]   <= prev_in[i];
				neg_s1[i] <= diff[i][SAMPLE_W];
				mag_s1[i] <= diff[i][SAMPLE_W] ? ndiff[i][SAMPLE_W-1:0] : diff[i][SAMPLE_W-1:0];
				a_s2[i]    <= a_s1[i];
				neg_s2[i]  <= neg_s1[i];
				prod_s2[i] <= PROD_W'(mag_s1[i]) * PROD_W'(frac_s1);
				res_s3[i]  <= res[i];
			end
			frac_s1 <= job.frac;
			last_s1 <= job.run_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_valid          = v_s3;
	assign out_data.left_out  = res_s3[0];
	assign out_data.right_out = res_s3[1];
	assign out_data.run_last  = last_s3;

`ifndef NO_ASSERTIONS
	a_pop_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped job did not enter the pipeline");
`endif

endmodule

`default_nettype wire

>>> hdl/stereo_linear_resampler_unit.sv
// Top level of the stereo linear resampler: front sequencer, job queue, back end.
// Depends on slr_pkg, slr_front, slr_queue, slr_back.
//
// Input channel in_valid/in_stall/in_data carries one stereo frame per transfer;
// output channel out_valid/out_stall/out_data carries one interpolated frame per
// transfer, run_last marking the final output caused by an input frame.
// cfg_we/cfg_data writes phase_step (Q4.16, input frames per output frame).
// The front sequencer issues one job per cycle while the queue is not full; an
// input frame yields 0 to 4 output frames.
// The first output of a frame passes the sequencer, the queue and the three-stage
// multiply pipeline ending in the output register.
// A 4-entry job queue separates front and back, so input transfers continue while
// the receiver stalls, until the queue is full.
// Reset clears previous frame, phase and primed flag, and sets phase_step to 60211;
// the first frame after reset or after a track end only primes the block.
`default_nettype none

module stereo_linear_resampler_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  slr_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  wire                        out_stall,
	output slr_pkg::out_item_t         out_data,
	input  wire                        cfg_we,
	input  wire [slr_pkg::STEP_W-1:0]  cfg_data
);
	import slr_pkg::*;

	job_t      push_job;
	job_t      pop_job;
	logic      push;
	logic      pop;
	q_status_t q_status;

	slr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_status (q_status),
		.push     (push),
		.job      (push_job)
	);

	slr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.status    (q_status)
	);

	slr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
